// File: hdl/swept_segment_circle_intersect_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the swept segment / circle hit test
// Concurrent checks sampled on the rising clock, muted while reset is low.
// ----------------------------------------------------------------------------
`ifndef SWEPT_SEGMENT_CIRCLE_INTERSECT_DEFINES_SVH
`define SWEPT_SEGMENT_CIRCLE_INTERSECT_DEFINES_SVH

// same-cycle implication
`define SSCI_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSCI_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/ssci_pkg.sv
// ----------------------------------------------------------------------------
// ssci_pkg
// Shared constants, operand tables and types of the segment / circle test.
// ----------------------------------------------------------------------------
package ssci_pkg;

	localparam int COORD_WIDTH_DEF = 20;

	// coordinate inputs
	localparam int NCOORD = 10;
	localparam int C_S0X = 0;
	localparam int C_S0Y = 1;
	localparam int C_S1X = 2;
	localparam int C_S1Y = 3;
	localparam int C_CX  = 4;
	localparam int C_CY  = 5;
	localparam int C_PX  = 6;
	localparam int C_PY  = 7;
	localparam int C_QX  = 8;
	localparam int C_QY  = 9;

	// first-stage differences
	localparam int NDIFF  = 18;
	localparam int D_MX   = 0;
	localparam int D_MY   = 1;
	localparam int D_S0PX = 2;
	localparam int D_S0PY = 3;
	localparam int D_S1PX = 4;
	localparam int D_S1PY = 5;
	localparam int D_SX   = 6;
	localparam int D_SY   = 7;
	localparam int D_PS0X = 8;
	localparam int D_PS0Y = 9;
	localparam int D_QS0X = 10;
	localparam int D_QS0Y = 11;
	localparam int D_S0CX = 12;
	localparam int D_S0CY = 13;
	localparam int D_S1CX = 14;
	localparam int D_S1CY = 15;
	localparam int D_EX   = 16;
	localparam int D_EY   = 17;

	localparam int DIFF_PLUS [NDIFF] = '{
		C_QX, C_QY, C_S0X, C_S0Y, C_S1X, C_S1Y, C_S1X, C_S1Y, C_PX,
		C_PY, C_QX, C_QY, C_S0X, C_S0Y, C_S1X, C_S1Y, C_CX, C_CY};
	localparam int DIFF_MINUS [NDIFF] = '{
		C_PX, C_PY, C_PX, C_PY, C_PX, C_PY, C_S0X, C_S0Y, C_S0X,
		C_S0Y, C_S0X, C_S0Y, C_CX, C_CY, C_CX, C_CY, C_S0X, C_S0Y};

	// second-stage products
	localparam int NPROD = 18;
	localparam int P_A1L = 0;
	localparam int P_A1R = 1;
	localparam int P_A2L = 2;
	localparam int P_A2R = 3;
	localparam int P_B1L = 4;
	localparam int P_B1R = 5;
	localparam int P_B2L = 6;
	localparam int P_B2R = 7;
	localparam int P_E0X = 8;
	localparam int P_E0Y = 9;
	localparam int P_E1X = 10;
	localparam int P_E1Y = 11;
	localparam int P_LX  = 12;
	localparam int P_LY  = 13;
	localparam int P_IX  = 14;
	localparam int P_IY  = 15;
	localparam int P_CL  = 16;
	localparam int P_CR  = 17;

	localparam int PROD_A [NPROD] = '{
		D_MX, D_MY, D_MX, D_MY, D_SX, D_SY, D_SX, D_SY, D_S0CX,
		D_S0CY, D_S1CX, D_S1CY, D_SX, D_SY, D_SX, D_SY, D_SX, D_SY};
	localparam int PROD_B [NPROD] = '{
		D_S0PY, D_S0PX, D_S1PY, D_S1PX, D_PS0Y, D_PS0X, D_QS0Y, D_QS0X, D_S0CX,
		D_S0CY, D_S1CX, D_S1CY, D_SX, D_SY, D_EX, D_EY, D_EY, D_EX};

	typedef enum logic [1:0] {
		CAUSE_NONE = 2'd0,
		CAUSE_PATH = 2'd1,
		CAUSE_END  = 2'd2,
		CAUSE_PROJ = 2'd3
	} cause_t;

	// per-stage load strobes
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_ld_t;

	// test outcomes, already gated by the enable
	typedef struct packed {
		logic path;
		logic endp;
		logic proj;
	} test_flags_t;

endpackage

// File: hdl/ssci_front.sv
// ----------------------------------------------------------------------------
// ssci_front
// Stages 1 and 2: coordinate differences, then the eighteen products and r^2.
// ----------------------------------------------------------------------------
module ssci_front #(
	parameter int COORD_WIDTH = ssci_pkg::COORD_WIDTH_DEF
) (
	input  logic                           clk,
	input  ssci_pkg::stage_ld_t            ld,
	input  logic signed [COORD_WIDTH-1:0]  coord [ssci_pkg::NCOORD],
	input  logic [COORD_WIDTH-2:0]         radius,
	input  logic                           en_in,
	output logic signed [2*COORD_WIDTH+1:0] prod_s2 [ssci_pkg::NPROD],
	output logic [2*COORD_WIDTH-3:0]       r2_s2,
	output logic                           en_s2
);

	localparam int DW  = COORD_WIDTH + 1;
	localparam int PW  = 2 * DW;
	localparam int RW  = COORD_WIDTH - 1;
	localparam int R2W = 2 * RW;

	logic signed [DW-1:0] diff_s1 [ssci_pkg::NDIFF];
	logic [RW-1:0]        radius_s1;
	logic                 en_s1;

	for (genvar i = 0; i < ssci_pkg::NDIFF; i++) begin : g_diff
		always_ff @(posedge clk) begin
			if (ld.s1) begin
				diff_s1[i] <=
					$signed({coord[ssci_pkg::DIFF_PLUS[i]][COORD_WIDTH-1],
					         coord[ssci_pkg::DIFF_PLUS[i]]}) -
					$signed({coord[ssci_pkg::DIFF_MINUS[i]][COORD_WIDTH-1],
					         coord[ssci_pkg::DIFF_MINUS[i]]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			radius_s1 <= radius;
			en_s1     <= en_in;
		end
	end

	for (genvar i = 0; i < ssci_pkg::NPROD; i++) begin : g_prod
		always_ff @(posedge clk) begin
			if (ld.s2) begin
				prod_s2[i] <= PW'(diff_s1[ssci_pkg::PROD_A[i]]) *
				              PW'(diff_s1[ssci_pkg::PROD_B[i]]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			r2_s2 <= R2W'(radius_s1) * R2W'(radius_s1);
			en_s2 <= en_s1;
		end
	end

endmodule

// File: hdl/ssci_tests.sv
// ----------------------------------------------------------------------------
// ssci_tests
// Stage 3: cross/dot sums, path and endpoint decisions, projection window.
// ----------------------------------------------------------------------------
module ssci_tests #(
	parameter int COORD_WIDTH = ssci_pkg::COORD_WIDTH_DEF
) (
	input  logic                            clk,
	input  ssci_pkg::stage_ld_t             ld,
	input  logic signed [2*COORD_WIDTH+1:0] prod_s2 [ssci_pkg::NPROD],
	input  logic [2*COORD_WIDTH-3:0]        r2_s2,
	input  logic                            en_s2,
	output ssci_pkg::test_flags_t           flags_s3,
	output logic [2*COORD_WIDTH:0]          crabs_s3,
	output logic [2*COORD_WIDTH:0]          len2_s3,
	output logic [2*COORD_WIDTH-3:0]        r2_s3
);

	localparam int PW  = 2 * COORD_WIDTH + 2;
	localparam int SW  = PW + 1;
	localparam int CW  = 2 * COORD_WIDTH + 1;
	localparam int R2W = 2 * COORD_WIDTH - 2;

	function automatic logic signed [SW-1:0] ext(input logic signed [PW-1:0] p);
		return $signed({p[PW-1], p});
	endfunction

	logic signed [SW-1:0] a1, a2, b1, b2;
	logic signed [SW-1:0] dist0, dist1, r2x;
	logic signed [SW-1:0] len2, inner, cr, crmag;
	logic signed [SW:0]   gap;
	ssci_pkg::test_flags_t flags_c;

	always_comb begin
		a1 = ext(prod_s2[ssci_pkg::P_A1L]) - ext(prod_s2[ssci_pkg::P_A1R]);
		a2 = ext(prod_s2[ssci_pkg::P_A2L]) - ext(prod_s2[ssci_pkg::P_A2R]);
		b1 = ext(prod_s2[ssci_pkg::P_B1L]) - ext(prod_s2[ssci_pkg::P_B1R]);
		b2 = ext(prod_s2[ssci_pkg::P_B2L]) - ext(prod_s2[ssci_pkg::P_B2R]);

		dist0 = ext(prod_s2[ssci_pkg::P_E0X]) + ext(prod_s2[ssci_pkg::P_E0Y]);
		dist1 = ext(prod_s2[ssci_pkg::P_E1X]) + ext(prod_s2[ssci_pkg::P_E1Y]);
		r2x   = $signed({{(SW - R2W){1'b0}}, r2_s2});

		len2  = ext(prod_s2[ssci_pkg::P_LX]) + ext(prod_s2[ssci_pkg::P_LY]);
		inner = ext(prod_s2[ssci_pkg::P_IX]) + ext(prod_s2[ssci_pkg::P_IY]);
		gap   = $signed({len2[SW-1], len2}) - $signed({inner[SW-1], inner});

		cr    = ext(prod_s2[ssci_pkg::P_CL]) - ext(prod_s2[ssci_pkg::P_CR]);
		crmag = cr[SW-1] ? -cr : cr;

		// segment endpoints straddle or touch the path line, and the path
		// endpoints lie strictly on opposite sides of the segment line
		flags_c.path = en_s2 &&
			(a1 == '0 || a2 == '0 || a1[SW-1] != a2[SW-1]) &&
			(b1 != '0 && b2 != '0 && b1[SW-1] != b2[SW-1]);
		flags_c.endp = en_s2 && (dist0 < r2x || dist1 < r2x);
		// zero-length segment never passes
		flags_c.proj = en_s2 && len2 != '0 && !inner[SW-1] && !gap[SW];
	end

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			flags_s3 <= flags_c;
			crabs_s3 <= crmag[CW-1:0];
			len2_s3  <= len2[CW-1:0];
			r2_s3    <= r2_s2;
		end
	end

endmodule

// File: hdl/ssci_wcmp.sv
// ----------------------------------------------------------------------------
// ssci_wcmp
// Stages 4-6: cross^2 < r^2 * len^2 from split partial products, then cause.
// ----------------------------------------------------------------------------
module ssci_wcmp #(
	parameter int COORD_WIDTH = ssci_pkg::COORD_WIDTH_DEF
) (
	input  logic                     clk,
	input  ssci_pkg::stage_ld_t      ld,
	input  ssci_pkg::test_flags_t    flags_s3,
	input  logic [2*COORD_WIDTH:0]   crabs_s3,
	input  logic [2*COORD_WIDTH:0]   len2_s3,
	input  logic [2*COORD_WIDTH-3:0] r2_s3,
	output logic                     hit_s6,
	output ssci_pkg::cause_t         cause_s6
);

	localparam int CW   = 2 * COORD_WIDTH + 1;
	localparam int H    = (CW + 1) / 2;
	localparam int CH   = CW - H;
	localparam int R2W  = 2 * COORD_WIDTH - 2;
	localparam int RH   = (R2W + 1) / 2;
	localparam int RHI  = R2W - RH;
	localparam int LW   = 2 * CW;
	localparam int HHW  = 2 * CH;
	localparam int HLW  = CH + H;
	localparam int LLW  = 2 * H;
	localparam int RLLW = RH + H;
	localparam int RLHW = RH + CH;
	localparam int RHLW = RHI + H;
	localparam int RHHW = RHI + CH;

	logic [HHW-1:0]  cr_hh_s4;
	logic [HLW-1:0]  cr_hl_s4;
	logic [LLW-1:0]  cr_ll_s4;
	logic [RLLW-1:0] rl_ll_s4;
	logic [RLHW-1:0] rl_lh_s4;
	logic [RHLW-1:0] rl_hl_s4;
	logic [RHHW-1:0] rl_hh_s4;
	ssci_pkg::test_flags_t flags_s4, flags_s5;
	logic [LW-1:0]   lhs_s5, rhs_s5;
	ssci_pkg::cause_t cause_c;

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			cr_hh_s4 <= HHW'(crabs_s3[CW-1:H]) * HHW'(crabs_s3[CW-1:H]);
			cr_hl_s4 <= HLW'(crabs_s3[CW-1:H]) * HLW'(crabs_s3[H-1:0]);
			cr_ll_s4 <= LLW'(crabs_s3[H-1:0]) * LLW'(crabs_s3[H-1:0]);
			rl_ll_s4 <= RLLW'(r2_s3[RH-1:0]) * RLLW'(len2_s3[H-1:0]);
			rl_lh_s4 <= RLHW'(r2_s3[RH-1:0]) * RLHW'(len2_s3[CW-1:H]);
			rl_hl_s4 <= RHLW'(r2_s3[R2W-1:RH]) * RHLW'(len2_s3[H-1:0]);
			rl_hh_s4 <= RHHW'(r2_s3[R2W-1:RH]) * RHHW'(len2_s3[CW-1:H]);
			flags_s4 <= flags_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s5) begin
			// the middle square term appears twice
			lhs_s5 <= (LW'(cr_hh_s4) << (2 * H)) + (LW'(cr_hl_s4) << (H + 1)) +
			          LW'(cr_ll_s4);
			rhs_s5 <= (LW'(rl_hh_s4) << (RH + H)) + (LW'(rl_hl_s4) << RH) +
			          (LW'(rl_lh_s4) << H) + LW'(rl_ll_s4);
			flags_s5 <= flags_s4;
		end
	end

	// lowest numbered cause wins
	always_comb begin
		if (flags_s5.path) begin
			cause_c = ssci_pkg::CAUSE_PATH;
		end else if (flags_s5.endp) begin
			cause_c = ssci_pkg::CAUSE_END;
		end else if (flags_s5.proj && lhs_s5 < rhs_s5) begin
			cause_c = ssci_pkg::CAUSE_PROJ;
		end else begin
			cause_c = ssci_pkg::CAUSE_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s6) begin
			cause_s6 <= cause_c;
			hit_s6   <= (cause_c != ssci_pkg::CAUSE_NONE);
		end
	end

endmodule

// File: hdl/swept_segment_circle_intersect.sv
// ----------------------------------------------------------------------------
// swept_segment_circle_intersect - swept circle versus segment hit test
// Depth: six register stages, s1 to s6; s6 is the output register.
// Throughput: one request per cycle while the result channel is not stalled.
// Reset: arst_n low clears all stage valid bits at once; data regs are unreset.
// ----------------------------------------------------------------------------
//
// Pipeline:
//   s1  coordinate differences (COORD_WIDTH+1 bits)
//   s2  eighteen products plus r^2, each one multiplier deep
//   s3  cross / dot sums: path crossing, endpoint inside, projection window
//   s4  split partial products of cross^2 and r^2 * |seg|^2
//   s5  recombination of the partial products into two wide words
//   s6  wide compare and cause priority; this is the output register
//
// Every stage holds its own valid bit and may fill while later stages stall,
// so bubbles collapse and a waiting result does not block new requests until
// the whole pipe is full. Fraction bits do not enter: every test compares
// terms of equal scale.
module swept_segment_circle_intersect #(
	parameter int COORD_WIDTH = ssci_pkg::COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,

	// request channel
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// tdata, from bit 0: seg_start_x, seg_start_y, seg_end_x, seg_end_y,
	// center_x, center_y, circle_radius (COORD_WIDTH-1 bits), prev_pos_x,
	// prev_pos_y, cur_pos_x, cur_pos_y, zero padding to whole bytes
	input  logic [((11 * COORD_WIDTH - 1 + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// tuser: both_enabled
	input  logic [0:0] s_axis_tuser,

	// result channel
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// tdata, from bit 0: hit, zero padding
	output logic [7:0] m_axis_tdata,
	// tuser: hit_cause
	output logic [1:0] m_axis_tuser
);

	localparam int W      = COORD_WIDTH;
	localparam int R_BASE = 6 * W;          // radius position in tdata
	localparam int P_BASE = 7 * W - 1;      // first coordinate after the radius

	// ---- request unpacking ----
	logic signed [W-1:0] coord [ssci_pkg::NCOORD];
	logic [W-2:0]        radius;

	for (genvar k = 0; k < ssci_pkg::C_PX; k++) begin : g_lo
		assign coord[k] = s_axis_tdata[k * W +: W];
	end
	for (genvar k = ssci_pkg::C_PX; k < ssci_pkg::NCOORD; k++) begin : g_hi
		assign coord[k] = s_axis_tdata[P_BASE + (k - ssci_pkg::C_PX) * W +: W];
	end
	assign radius = s_axis_tdata[R_BASE +: W - 1];

	// ---- stage valid bits and elastic handshake ----
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
	ssci_pkg::stage_ld_t ld;

	// a stage can take new data when empty or when its content moves on
	always_comb begin
		rdy6 = !v_s6 || m_axis_tready;
		rdy5 = !v_s5 || rdy6;
		rdy4 = !v_s4 || rdy5;
		rdy3 = !v_s3 || rdy4;
		rdy2 = !v_s2 || rdy3;
		rdy1 = !v_s1 || rdy2;

		// payload only loads when a valid item actually enters
		ld.s1 = rdy1 && s_axis_tvalid;
		ld.s2 = rdy2 && v_s1;
		ld.s3 = rdy3 && v_s2;
		ld.s4 = rdy4 && v_s3;
		ld.s5 = rdy5 && v_s4;
		ld.s6 = rdy6 && v_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_axis_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	assign s_axis_tready = rdy1;

	// ---- datapath ----
	logic signed [2*W+1:0] prod_s2 [ssci_pkg::NPROD];
	logic [2*W-3:0]        r2_s2, r2_s3;
	logic                  en_s2;
	ssci_pkg::test_flags_t flags_s3;
	logic [2*W:0]          crabs_s3, len2_s3;
	logic                  hit_s6;
	ssci_pkg::cause_t      cause_s6;

	ssci_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk     (clk),
		.ld      (ld),
		.coord   (coord),
		.radius  (radius),
		.en_in   (s_axis_tuser[0]),
		.prod_s2 (prod_s2),
		.r2_s2   (r2_s2),
		.en_s2   (en_s2)
	);

	ssci_tests #(.COORD_WIDTH(COORD_WIDTH)) u_tests (
		.clk      (clk),
		.ld       (ld),
		.prod_s2  (prod_s2),
		.r2_s2    (r2_s2),
		.en_s2    (en_s2),
		.flags_s3 (flags_s3),
		.crabs_s3 (crabs_s3),
		.len2_s3  (len2_s3),
		.r2_s3    (r2_s3)
	);

	ssci_wcmp #(.COORD_WIDTH(COORD_WIDTH)) u_wcmp (
		.clk      (clk),
		.ld       (ld),
		.flags_s3 (flags_s3),
		.crabs_s3 (crabs_s3),
		.len2_s3  (len2_s3),
		.r2_s3    (r2_s3),
		.hit_s6   (hit_s6),
		.cause_s6 (cause_s6)
	);

	// ---- result channel ----
	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata  = {7'b0, hit_s6};
	assign m_axis_tuser  = cause_s6;

endmodule

// File: hdl/ssci_checker.sv
// ----------------------------------------------------------------------------
// ssci_checker
// Port-level checks of the hit test, bound to the top level.
// ----------------------------------------------------------------------------
`include "swept_segment_circle_intersect_defines.svh"

module ssci_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [1:0] m_axis_tuser
);

	// a stalled result keeps its value
	`SSCI_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

	// hit flag agrees with its cause
	`SSCI_ASSERT_NOW(a_hit_cause, clk, arst_n, m_axis_tvalid, m_axis_tdata[0] == (m_axis_tuser != ssci_pkg::CAUSE_NONE), "hit and cause disagree")

	// padding bits stay zero
	`SSCI_ASSERT_NOW(a_pad_zero, clk, arst_n, m_axis_tvalid, m_axis_tdata[7:1] == 7'b0, "result padding not zero")

	// a draining output leaves room at the input
	`SSCI_ASSERT_NOW(a_ready_flow, clk, arst_n, m_axis_tready, s_axis_tready, "input blocked while output drains")

endmodule

bind swept_segment_circle_intersect ssci_checker u_ssci_checker (.*);

// File: tb/tb_swept_segment_circle_intersect.sv
// ----------------------------------------------------------------------------
// tb_swept_segment_circle_intersect
// Self-checking bench for the swept segment / circle hit test. Requests are
// streamed in through the slave side. Each accepted request is scored by an
// exact wide-integer model of the three tests and the cause priority. Results
// are compared in order at the master side; both sides may idle at random.
// ----------------------------------------------------------------------------
module tb_swept_segment_circle_intersect;

	localparam int CW      = ssci_pkg::COORD_WIDTH_DEF;
	localparam int TDATA_W = ((11 * CW - 1 + 7) / 8) * 8;
	localparam int PAD_W   = TDATA_W - (11 * CW - 1);
	localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
	localparam longint CMIN = -(64'sd1 <<< (CW - 1));
	localparam longint RMAX = (64'sd1 <<< (CW - 1)) - 1;
	// drain with ample margin after the last expected result
	localparam int DRAIN_CYCLES = 20;

	// wide enough for cross^2 and r^2 * |seg|^2 without overflow
	typedef logic signed [127:0] wide_t;

	// one query as it travels on the request channel
	typedef struct {
		logic signed [CW-1:0] s0x, s0y, s1x, s1y;
		logic signed [CW-1:0] cx, cy;
		logic        [CW-2:0] radius;
		logic signed [CW-1:0] px, py, qx, qy;
		logic                 en;
	} query_t;

	logic clk;
	logic arst_n = 1'b0;

	logic               s_valid = 1'b0;
	logic [TDATA_W-1:0] s_data  = '0;
	logic [0:0]         s_user  = '0;
	logic               m_ready = 1'b0;

	wire                s_axis_tready;
	wire                m_axis_tvalid;
	wire [7:0]          m_axis_tdata;
	wire [1:0]          m_axis_tuser;

	// random idling on both sides while set
	bit idle_on = 1'b1;

	ssci_pkg::cause_t pending_causes[$];
	int     mismatches;
	int     sent_count;
	int     cause_seen[4];

	swept_segment_circle_intersect #(
		.COORD_WIDTH(CW)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_valid),
		.s_axis_tready(s_axis_tready),
		// tdata, from bit 0: seg_start_x, seg_start_y, seg_end_x, seg_end_y,
		// center_x, center_y, circle_radius, prev_pos_x, prev_pos_y,
		// cur_pos_x, cur_pos_y, zero padding
		.s_axis_tdata (s_data),
		// tuser: both_enabled
		.s_axis_tuser (s_user),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_ready),
		// tdata, from bit 0: hit, zero padding
		.m_axis_tdata (m_axis_tdata),
		// tuser: hit_cause
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop, far beyond the slowest legal run
	initial begin
		#400000;
		$display("end of test: mismatches");
		$finish;
	end

	// ------------------------------------------------------------------
	// hit prediction
	// ------------------------------------------------------------------
	function automatic wide_t cross2(input longint ax, input longint ay,
			input longint bx, input longint by);
		return wide_t'(ax) * wide_t'(by) - wide_t'(ay) * wide_t'(bx);
	endfunction

	function automatic int sgn(input wide_t v);
		return (v < 0) ? -1 : ((v > 0) ? 1 : 0);
	endfunction

	function automatic ssci_pkg::cause_t hit_cause_of(input query_t q);
		longint s0x, s0y, s1x, s1y, cx, cy, r, px, py, qx, qy;
		longint mx, my, sx, sy, ex, ey;
		wide_t  r2, len2, inner, cr, d0, d1;
		int     a1, a2, b1, b2;
		s0x = longint'(q.s0x); s0y = longint'(q.s0y);
		s1x = longint'(q.s1x); s1y = longint'(q.s1y);
		cx  = longint'(q.cx);  cy  = longint'(q.cy);  r = longint'(q.radius);
		px  = longint'(q.px);  py  = longint'(q.py);
		qx  = longint'(q.qx);  qy  = longint'(q.qy);
		if (!q.en)
			return ssci_pkg::CAUSE_NONE;
		mx = qx - px;   my = qy - py;
		sx = s1x - s0x; sy = s1y - s0y;
		// path crossing: endpoints may touch the path line, prev/cur may not
		a1 = sgn(cross2(mx, my, s0x - px, s0y - py));
		a2 = sgn(cross2(mx, my, s1x - px, s1y - py));
		b1 = sgn(cross2(sx, sy, px - s0x, py - s0y));
		b2 = sgn(cross2(sx, sy, qx - s0x, qy - s0y));
		if (a1 * a2 <= 0 && b1 * b2 < 0)
			return ssci_pkg::CAUSE_PATH;
		r2 = wide_t'(r) * wide_t'(r);
		d0 = wide_t'(s0x - cx) * wide_t'(s0x - cx) + wide_t'(s0y - cy) * wide_t'(s0y - cy);
		d1 = wide_t'(s1x - cx) * wide_t'(s1x - cx) + wide_t'(s1y - cy) * wide_t'(s1y - cy);
		if (d0 < r2 || d1 < r2)
			return ssci_pkg::CAUSE_END;
		// projection window is inclusive; a zero length segment never qualifies
		ex = cx - s0x; ey = cy - s0y;
		len2  = wide_t'(sx) * wide_t'(sx) + wide_t'(sy) * wide_t'(sy);
		inner = wide_t'(sx) * wide_t'(ex) + wide_t'(sy) * wide_t'(ey);
		if (len2 > 0 && inner >= 0 && inner <= len2) begin
			cr = cross2(sx, sy, ex, ey);
			if (cr * cr < r2 * len2)
				return ssci_pkg::CAUSE_PROJ;
		end
		return ssci_pkg::CAUSE_NONE;
	endfunction

	// ------------------------------------------------------------------
	// query builders
	// ------------------------------------------------------------------
	function automatic query_t make_query(input longint s0x, s0y, s1x, s1y, cx, cy,
			r, px, py, qx, qy, input bit en);
		query_t q;
		q.s0x = CW'(s0x); q.s0y = CW'(s0y); q.s1x = CW'(s1x); q.s1y = CW'(s1y);
		q.cx  = CW'(cx);  q.cy  = CW'(cy);  q.radius = (CW-1)'(r);
		q.px  = CW'(px);  q.py  = CW'(py);  q.qx  = CW'(qx);  q.qy  = CW'(qy);
		q.en  = en;
		return q;
	endfunction

	function automatic longint coord_rand();
		logic signed [CW-1:0] v;
		v = CW'($urandom);
		return longint'(v);
	endfunction

	function automatic longint sat(input longint v);
		return (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
	endfunction

	function automatic longint jitter(input longint span);
		return longint'($urandom_range(0, 32'(2 * span))) - span;
	endfunction

	function automatic query_t noise_query();
		query_t q;
		q = make_query(coord_rand(), coord_rand(), coord_rand(), coord_rand(),
			coord_rand(), coord_rand(), 0, coord_rand(), coord_rand(),
			coord_rand(), coord_rand(), 1'($urandom_range(0, 1)));
		q.radius = (CW-1)'($urandom);
		return q;
	endfunction

	// geometry clustered around one point so that all three tests and the
	// touching cases come up; span sets the scale of the scene
	function automatic query_t random_scene(input longint span);
		query_t q;
		longint bx, by, mx, my, rlim;
		bx = coord_rand();
		by = coord_rand();
		q.s0x = CW'(sat(bx + jitter(span)));
		q.s0y = CW'(sat(by + jitter(span)));
		q.s1x = CW'(sat(bx + jitter(span)));
		q.s1y = CW'(sat(by + jitter(span)));
		mx = (longint'(q.s0x) + longint'(q.s1x)) / 2;
		my = (longint'(q.s0y) + longint'(q.s1y)) / 2;
		q.cx = CW'(sat(mx + jitter(span)));
		q.cy = CW'(sat(my + jitter(span)));
		q.px = CW'(sat(mx + jitter(2 * span)));
		q.py = CW'(sat(my + jitter(2 * span)));
		q.qx = CW'(sat(mx + jitter(2 * span)));
		q.qy = CW'(sat(my + jitter(2 * span)));
		rlim = (2 * span > RMAX) ? RMAX : 2 * span;
		q.radius = (CW-1)'($urandom_range(0, 32'(rlim)));
		if ($urandom_range(0, 15) == 0)
			q.radius = (CW-1)'(RMAX);
		q.en = ($urandom_range(0, 9) != 0);
		return q;
	endfunction

	function automatic longint pick_span();
		case ($urandom_range(0, 4))
			0: return 4;
			1: return 64;
			2: return 4096;
			3: return 1 << 14;
			default: return 1 << 18;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// request driver: one query, optional leading gap, wait for acceptance
	// ------------------------------------------------------------------
	task automatic send_query(input query_t q);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_valid <= 1'b1;
		s_data  <= {{PAD_W{1'b0}}, q.qy, q.qx, q.py, q.px, q.radius,
			q.cy, q.cx, q.s1y, q.s1x, q.s0y, q.s0x};
		s_user  <= q.en;
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_causes.push_back(hit_cause_of(q));
		sent_count++;
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("MISMATCH t=%0t: %s", $time, msg);
	endtask

	// ------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		ssci_pkg::cause_t want;
		if (arst_n && m_axis_tvalid && m_ready) begin
			if (pending_causes.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = pending_causes.pop_front();
				if (m_axis_tdata !== {7'd0, want != ssci_pkg::CAUSE_NONE})
					report_mismatch($sformatf("hit: got tdata %02h, want cause %s",
						m_axis_tdata, want.name()));
				if (m_axis_tuser !== want)
					report_mismatch($sformatf("hit_cause: got %0d, want %s",
						m_axis_tuser, want.name()));
				cause_seen[want]++;
			end
		end
	end

	// receiver backpressure in short random bursts
	initial begin
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 4) == 0) begin
				m_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				m_ready <= 1'b1;
			end else begin
				m_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_directed_corners();
		// field extremes
		send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
		send_query(make_query(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, RMAX,
			CMAX, CMAX, CMAX, CMAX, 1));
		send_query(make_query(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 0,
			CMIN, CMIN, CMIN, CMIN, 1));
		send_query(make_query(CMIN, CMIN, CMAX, CMAX, 0, 0, RMAX,
			CMIN, CMAX, CMAX, CMIN, 1));
		// same sweep with the bodies disabled
		send_query(make_query(CMIN, CMIN, CMAX, CMAX, 0, 0, RMAX,
			CMIN, CMAX, CMAX, CMIN, 0));
		send_query(make_query(CMIN, 0, CMAX, 0, CMIN, CMAX, RMAX,
			0, CMAX, 0, CMIN, 1));
		// clean path crossing
		send_query(make_query(-160, 0, 160, 0, 0, -320, 16, 0, 320, 0, -320, 1));
		// endpoint touches the path line: still a crossing
		send_query(make_query(0, 0, 160, 0, 0, -320, 16, 0, 320, 0, -320, 1));
		// previous position on the segment line: no crossing
		send_query(make_query(-160, 0, 160, 0, 0, -320, 16, 0, 0, 0, -320, 1));
		// current position on the segment line, center on segment
		send_query(make_query(-160, 0, 160, 0, 0, 0, 16, 0, 320, 0, 0, 1));
		// endpoint strictly inside
		send_query(make_query(10, 10, 500, 500, 0, 0, 16, 0, 0, 0, 0, 1));
		// endpoint exactly on the circle
		send_query(make_query(48, 64, 480, 640, 0, 0, 80, 0, 0, 0, 0, 1));
		// projection hit, then distance exactly equal to the radius
		send_query(make_query(-320, 32, 320, 32, 0, 0, 48, 0, 0, 0, 0, 1));
		send_query(make_query(-320, 32, 320, 32, 0, 0, 32, 0, 0, 0, 0, 1));
		// center projects onto the segment start
		send_query(make_query(0, 32, 320, 32, 0, 0, 32, 0, 0, 0, 0, 1));
		// center just before the segment start
		send_query(make_query(0, 32, 320, 32, -1, 0, 40, 0, 0, 0, 0, 1));
		// zero length segment just outside, and one swept across
		send_query(make_query(100, 100, 100, 100, 0, 0, 141, 0, 0, 0, 0, 1));
		send_query(make_query(0, 0, 0, 0, 200, 200, 10, -50, 0, 50, 0, 1));
		// circle that did not move, lying across the segment
		send_query(make_query(-100, 0, 100, 0, 0, 5, 10, 0, 0, 0, 0, 1));
		// crossing and endpoint inside at once: crossing wins
		send_query(make_query(0, 5, 0, -100, 0, 0, 16, -50, 0, 50, 0, 1));
		// zero radius on the segment
		send_query(make_query(-100, 0, 100, 0, 0, 0, 0, 0, 0, 0, 0, 1));
		// full radius, far away
		send_query(make_query(CMIN, CMIN, CMAX, CMIN, 0, CMAX, RMAX,
			0, CMAX, 0, CMAX, 1));
	endtask

	task automatic test_random_scenes(input int count);
		for (int i = 0; i < count; i++) begin
			// alternate stretches with and without idling
			if (i % 40 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			send_query(random_scene(pick_span()));
		end
		idle_on = 1'b1;
	endtask

	task automatic test_random_noise(input int count);
		repeat (count) send_query(noise_query());
	endtask

	task automatic test_degenerate_shapes(input int count);
		query_t q;
		longint k;
		repeat (count) begin
			q = random_scene(pick_span());
			case ($urandom_range(0, 4))
				0: begin
					q.s1x = q.s0x;
					q.s1y = q.s0y;
				end
				1: begin
					q.qx = q.px;
					q.qy = q.py;
				end
				2: q.radius = '0;
				3: begin
					// endpoint on the circle rim, 3-4-5 triangle
					k = longint'($urandom_range(1, 1000));
					q.s0x = CW'(sat(longint'(q.cx) + 3 * k));
					q.s0y = CW'(sat(longint'(q.cy) - 4 * k));
					q.radius = (CW-1)'(5 * k);
				end
				default: begin
					// center on the segment line
					q.cx = CW'(q.s0x + 2 * (q.s1x - q.s0x));
					q.cy = CW'(q.s0y + 2 * (q.s1y - q.s0y));
				end
			endcase
			send_query(q);
		end
	endtask

	task automatic test_full_rate(input int count);
		idle_on = 1'b0;
		repeat (count) begin
			if ($urandom_range(0, 4) == 0)
				send_query(noise_query());
			else
				send_query(random_scene(pick_span()));
		end
	endtask

	task automatic finish_run();
		s_valid <= 1'b0;
		while (pending_causes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests; causes none/path/endpoint/projection: %0d/%0d/%0d/%0d",
			sent_count, cause_seen[ssci_pkg::CAUSE_NONE], cause_seen[ssci_pkg::CAUSE_PATH],
			cause_seen[ssci_pkg::CAUSE_END], cause_seen[ssci_pkg::CAUSE_PROJ]);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		test_random_scenes(320);
		test_random_noise(80);
		test_degenerate_shapes(50);
		test_full_rate(60);
		finish_run();
	end

endmodule
